### sv/rpsm_pkg.sv
package rpsm_pkg;

    // table geometry
    localparam int DEPTH    = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 2);
    localparam int FREQ_W   = 16;
    localparam int OP_W     = 4;
    localparam int OUT_CNT_W = 6;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_US_BOTTOM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_US_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JP_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JP_TOP    = 3'd4;

    // band modes
    localparam logic [1:0] BAND_US = 2'd0;
    localparam logic [1:0] BAND_JP = 2'd1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_NEXT    = 4'd0,
        OP_PREV    = 4'd1,
        OP_CUR     = 4'd2,
        OP_UP      = 4'd3,
        OP_DOWN    = 4'd4,
        OP_SAVE    = 4'd5,
        OP_DEL_ONE = 4'd6,
        OP_DEL_ALL = 4'd7,
        OP_SET     = 4'd8
    } op_t;

    // table access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic              clr;
        logic [IDX_W-1:0]  wr_idx;
        logic [FREQ_W-1:0] wr_data;
        logic [IDX_W-1:0]  rd_idx;
    } tbl_ctrl_t;

endpackage

### sv/rpsm_req_if.sv
interface rpsm_req_if;
    logic                        valid;
    logic                        ready;
    logic [rpsm_pkg::OP_W-1:0]   op;
    logic [rpsm_pkg::FREQ_W-1:0] new_freq;

    modport source (output valid, output op, output new_freq, input ready);
    modport sink   (input valid, input op, input new_freq, output ready);
endinterface

### sv/rpsm_rsp_if.sv
interface rpsm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic                           tune;
    logic [rpsm_pkg::FREQ_W-1:0]    freq;
    logic [rpsm_pkg::OUT_CNT_W-1:0] preset;
    logic [rpsm_pkg::OUT_CNT_W-1:0] preset_count;

    modport source (output valid, output ok, output tune, output freq,
                    output preset, output preset_count, input ready);
    modport sink   (input valid, input ok, input tune, input freq,
                    input preset, input preset_count, output ready);
endinterface

### sv/radio_preset_station_manager_unit.sv
// channel   dir  payload                                   beat when
// req       in   op, new_freq                              valid && ready
// rsp       out  ok, tune, freq, preset, preset_count      valid && ready
// cfg       in   cfg_index, cfg_data                       cfg_we
//
// grid, set, delete all and refused ops go from accept straight to the done step.
// next/previous/current scan the table one entry a cycle.
// save compares one stored entry a cycle.
// delete one moves one entry a cycle down from the selected preset, then clears the last used entry.
// the single table read port and the scan compare set these rates.
// reset clears the table flops at once; a result waiting on rsp holds the next item in done.
module radio_preset_station_manager_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rpsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpsm_pkg::CFG_DATA_W-1:0] cfg_data,
    rpsm_req_if.sink                        req,
    rpsm_rsp_if.source                      rsp
);

    localparam int CNT_W  = rpsm_pkg::CNT_W;
    localparam int IDX_W  = rpsm_pkg::IDX_W;
    localparam int FREQ_W = rpsm_pkg::FREQ_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NAV,
        ST_SAVE,
        ST_DEL,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]        band_reg;
    logic [FREQ_W-1:0] us_bot_reg, us_top_reg, jp_bot_reg, jp_top_reg;

    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [CNT_W-1:0]  preset_reg, preset_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic              prev_reg, prev_next;
    logic              ok_reg, ok_next;
    logic              tune_reg, tune_next;

    logic                          rsp_valid_reg, rsp_valid_next;
    logic                          rsp_ok_reg, rsp_ok_next;
    logic                          rsp_tune_reg, rsp_tune_next;
    logic [FREQ_W-1:0]             rsp_freq_reg, rsp_freq_next;
    logic [rpsm_pkg::OUT_CNT_W-1:0] rsp_preset_reg, rsp_preset_next;
    logic [rpsm_pkg::OUT_CNT_W-1:0] rsp_count_reg, rsp_count_next;

    rpsm_pkg::tbl_ctrl_t tbl;
    logic [FREQ_W-1:0]   rd_data;

    logic [FREQ_W:0]   freq_inc;
    logic [FREQ_W-1:0] freq_dec;
    logic [FREQ_W-1:0] up_freq, down_freq;
    logic [CNT_W-1:0]  nav_target;
    logic [CNT_W-1:0]  seen_cur;
    logic [CNT_W:0]    seen_plus;
    logic [CNT_W-1:0]  seen_cap;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  count_dec;

    rpsm_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tbl),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg   <= rpsm_pkg::BAND_US;
            us_bot_reg <= 16'd875;
            us_top_reg <= 16'd1080;
            jp_bot_reg <= 16'd760;
            jp_top_reg <= 16'd900;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpsm_pkg::CFG_BAND_MODE: band_reg   <= cfg_data[1:0];
                rpsm_pkg::CFG_US_BOTTOM: us_bot_reg <= cfg_data;
                rpsm_pkg::CFG_US_TOP:    us_top_reg <= cfg_data;
                rpsm_pkg::CFG_JP_BOTTOM: jp_bot_reg <= cfg_data;
                rpsm_pkg::CFG_JP_TOP:    jp_top_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // grid step with band wrap
    always_comb
    begin
        freq_inc = {1'b0, freq_reg} + 1'b1;
        freq_dec = freq_reg - 1'b1;
        if (band_reg == rpsm_pkg::BAND_US && freq_inc > {1'b0, us_top_reg})
            up_freq = us_bot_reg;
        else if (band_reg == rpsm_pkg::BAND_JP && freq_inc > {1'b0, jp_top_reg})
            up_freq = jp_bot_reg;
        else
            up_freq = freq_inc[FREQ_W-1:0];
        if (band_reg == rpsm_pkg::BAND_US && (freq_reg == '0 || freq_dec < us_bot_reg))
            down_freq = us_top_reg;
        else if (band_reg == rpsm_pkg::BAND_JP && (freq_reg == '0 || freq_dec < jp_bot_reg))
            down_freq = jp_top_reg;
        else
            down_freq = freq_dec;
    end

    // preset wanted by next, previous and current
    always_comb
    begin
        case (req.op)
            rpsm_pkg::OP_NEXT:
                nav_target = ((preset_reg >= count_reg) ? '0 : preset_reg) + 1'b1;
            rpsm_pkg::OP_PREV:
                nav_target = (preset_reg <= CNT_W'(1)) ? count_reg : preset_reg - 1'b1;
            default:
                nav_target = (preset_reg == '0) ? CNT_W'(1) : preset_reg;
        endcase
    end

    // shared scan arithmetic
    always_comb
    begin
        seen_cur  = (rd_data != '0) ? seen_reg + 1'b1 : seen_reg;
        seen_plus = {1'b0, seen_cur} + 1'b1;
        seen_cap  = (seen_plus > (CNT_W + 1)'(rpsm_pkg::DEPTH))
                    ? CNT_W'(rpsm_pkg::DEPTH) : seen_plus[CNT_W-1:0];
        idx_dec   = idx_reg - 1'b1;
        count_dec = count_reg - 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        freq_next   = freq_reg;
        preset_next = preset_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        seen_next   = seen_reg;
        prev_next   = prev_reg;
        ok_next     = ok_reg;
        tune_next   = tune_reg;

        rsp_valid_next  = rsp.ready ? 1'b0 : rsp_valid_reg;
        rsp_ok_next     = rsp_ok_reg;
        rsp_tune_next   = rsp_tune_reg;
        rsp_freq_next   = rsp_freq_reg;
        rsp_preset_next = rsp_preset_reg;
        rsp_count_next  = rsp_count_reg;

        tbl.wr_en   = 1'b0;
        tbl.clr     = 1'b0;
        tbl.wr_idx  = idx_reg[IDX_W-1:0];
        tbl.wr_data = '0;
        tbl.rd_idx  = idx_reg[IDX_W-1:0];

        req.ready = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    ok_next    = 1'b1;
                    tune_next  = 1'b0;
                    idx_next   = '0;
                    seen_next  = '0;
                    state_next = ST_DONE;
                    case (req.op)
                        rpsm_pkg::OP_NEXT, rpsm_pkg::OP_PREV, rpsm_pkg::OP_CUR:
                        begin
                            if (count_reg == '0)
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                tune_next   = 1'b1;
                                preset_next = nav_target;
                                prev_next   = (req.op == rpsm_pkg::OP_PREV);
                                state_next  = ST_NAV;
                            end
                        end
                        rpsm_pkg::OP_UP:
                        begin
                            freq_next = up_freq;
                            tune_next = 1'b1;
                        end
                        rpsm_pkg::OP_DOWN:
                        begin
                            freq_next = down_freq;
                            tune_next = 1'b1;
                        end
                        rpsm_pkg::OP_SAVE:
                        begin
                            if (count_reg >= CNT_W'(rpsm_pkg::DEPTH))
                                ok_next = 1'b0;
                            else
                                state_next = ST_SAVE;
                        end
                        rpsm_pkg::OP_DEL_ONE:
                        begin
                            if (preset_reg == '0)
                            begin
                                ok_next = 1'b0;
                            end
                            else if (count_reg == '0)
                            begin
                                preset_next = '0;
                            end
                            else
                            begin
                                idx_next   = preset_reg;
                                state_next = ST_DEL;
                            end
                        end
                        rpsm_pkg::OP_DEL_ALL:
                        begin
                            tbl.clr     = 1'b1;
                            preset_next = '0;
                            count_next  = '0;
                        end
                        rpsm_pkg::OP_SET:
                        begin
                            freq_next = req.new_freq;
                            tune_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            // walk the table for the nth non-zero entry
            ST_NAV:
            begin
                if (rd_data != '0 && seen_cur == preset_reg)
                begin
                    freq_next  = rd_data;
                    state_next = ST_DONE;
                end
                else if (idx_reg == CNT_W'(rpsm_pkg::DEPTH - 1))
                begin
                    // entry missing: repair preset and count
                    if (prev_reg)
                    begin
                        preset_next = seen_cap;
                        count_next  = seen_cap;
                    end
                    else
                    begin
                        count_next  = (seen_cur != '0) ? seen_cur - 1'b1 : '0;
                        preset_next = CNT_W'(1);
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    seen_next = seen_cur;
                end
            end

            // duplicate search, then append
            ST_SAVE:
            begin
                if (idx_reg == count_reg)
                begin
                    tbl.wr_en   = 1'b1;
                    tbl.wr_idx  = count_reg[IDX_W-1:0];
                    tbl.wr_data = freq_reg;
                    count_next  = count_reg + 1'b1;
                    preset_next = count_reg + 1'b1;
                    state_next  = ST_DONE;
                end
                else if (rd_data == freq_reg)
                begin
                    preset_next = idx_reg + 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // compaction, one entry a cycle, then clear the last used one
            ST_DEL:
            begin
                tbl.wr_en = 1'b1;
                if (idx_reg < count_reg)
                begin
                    tbl.wr_idx  = idx_dec[IDX_W-1:0];
                    tbl.wr_data = rd_data;
                    idx_next    = idx_reg + 1'b1;
                end
                else
                begin
                    tbl.wr_idx  = count_dec[IDX_W-1:0];
                    tbl.wr_data = '0;
                    count_next  = count_dec;
                    preset_next = '0;
                    state_next  = ST_DONE;
                end
            end

            // hand the result to the output register
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_ok_next     = ok_reg;
                    rsp_tune_next   = tune_reg;
                    rsp_freq_next   = freq_reg;
                    rsp_preset_next = rpsm_pkg::OUT_CNT_W'(preset_reg);
                    rsp_count_next  = rpsm_pkg::OUT_CNT_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            freq_reg      <= '0;
            preset_reg    <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            freq_reg      <= freq_next;
            preset_reg    <= preset_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        seen_reg       <= seen_next;
        prev_reg       <= prev_next;
        ok_reg         <= ok_next;
        tune_reg       <= tune_next;
        rsp_ok_reg     <= rsp_ok_next;
        rsp_tune_reg   <= rsp_tune_next;
        rsp_freq_reg   <= rsp_freq_next;
        rsp_preset_reg <= rsp_preset_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.ok           = rsp_ok_reg;
    assign rsp.tune         = rsp_tune_reg;
    assign rsp.freq         = rsp_freq_reg;
    assign rsp.preset       = rsp_preset_reg;
    assign rsp.preset_count = rsp_count_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(rpsm_pkg::DEPTH))
        else $error("preset count beyond table depth");

    a_preset_range: assert property (@(posedge clk) disable iff (!rst_n)
        preset_reg <= CNT_W'(rpsm_pkg::DEPTH))
        else $error("preset number beyond table depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after an accepted beat");

    a_delete_all: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == rpsm_pkg::OP_DEL_ALL)
        |=> (count_reg == '0 && preset_reg == '0))
        else $error("delete all left presets behind");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done step");

endmodule

### sv/rpsm_table.sv
module rpsm_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpsm_pkg::tbl_ctrl_t         ctrl,
    output logic [rpsm_pkg::FREQ_W-1:0] rd_data
);

    logic [rpsm_pkg::FREQ_W-1:0] entry_reg [rpsm_pkg::DEPTH];

    // one read port at the scan index
    assign rd_data = entry_reg[ctrl.rd_idx];

    // preset storage, cleared at reset and by delete all
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rpsm_pkg::DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (ctrl.clr)
        begin
            for (int i = 0; i < rpsm_pkg::DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (ctrl.wr_en)
        begin
            entry_reg[ctrl.wr_idx] <= ctrl.wr_data;
        end
    end

endmodule

### tb/sv/tb_top.sv
import rpsm_pkg::*;

// one response beat as seen on the rsp channel
typedef struct packed {
    logic                 ok;
    logic                 tune;
    logic [FREQ_W-1:0]    freq;
    logic [OUT_CNT_W-1:0] preset;
    logic [OUT_CNT_W-1:0] preset_count;
} station_report_t;

// mirror of the preset table and the tuning state, plus the reports still owed
class preset_station_tracker;
    logic [1:0]        band_mode;
    logic [FREQ_W-1:0] us_lo;
    logic [FREQ_W-1:0] us_hi;
    logic [FREQ_W-1:0] jp_lo;
    logic [FREQ_W-1:0] jp_hi;
    logic [FREQ_W-1:0] stations [DEPTH];
    logic [FREQ_W-1:0] cur_freq;
    int                cur_preset;
    int                stored_total;
    station_report_t   owed_reports [$];
    int                errors;

    function new();
        band_mode    = BAND_US;
        us_lo        = 16'd875;
        us_hi        = 16'd1080;
        jp_lo        = 16'd760;
        jp_hi        = 16'd900;
        foreach (stations[i])
            stations[i] = '0;
        cur_freq     = '0;
        cur_preset   = 0;
        stored_total = 0;
        errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BAND_MODE: band_mode = data[1:0];
            CFG_US_BOTTOM: us_lo     = data;
            CFG_US_TOP:    us_hi     = data;
            CFG_JP_BOTTOM: jp_lo     = data;
            CFG_JP_TOP:    jp_hi     = data;
            default: ;
        endcase
    endfunction

    // position of the nth non-zero station, DEPTH when there is none
    function int nth_station(int nth, output int seen);
        int idx;
        seen = 0;
        for (idx = 0; idx < DEPTH; idx++)
        begin
            if (stations[idx] != '0)
            begin
                seen++;
                if (seen == nth)
                    break;
            end
        end
        return idx;
    endfunction

    // apply one accepted command and queue the report it owes
    function void note_command(logic [OP_W-1:0] op, logic [FREQ_W-1:0] nf);
        station_report_t want;
        logic            ok;
        logic            tune;
        int              idx;
        int              seen;
        int              f_now;
        bit              dup;
        ok   = 1'b1;
        tune = 1'b0;
        f_now = int'(cur_freq);
        if (op == OP_NEXT || op == OP_PREV || op == OP_CUR)
        begin
            if (stored_total == 0)
            begin
                ok = 1'b0;
            end
            else
            begin
                tune = 1'b1;
                if (op == OP_NEXT)
                begin
                    if (cur_preset >= stored_total)
                        cur_preset = 0;
                    cur_preset++;
                end
                else if (op == OP_PREV)
                begin
                    if (cur_preset <= 1)
                        cur_preset = stored_total + 1;
                    cur_preset--;
                end
                else if (cur_preset == 0)
                begin
                    cur_preset = 1;
                end
                idx = nth_station(cur_preset, seen);
                // entry missing: repair the count and the selection
                if (idx < DEPTH)
                begin
                    cur_freq = stations[idx];
                end
                else if (op == OP_PREV)
                begin
                    seen++;
                    if (seen > DEPTH)
                        seen = DEPTH;
                    cur_preset   = seen;
                    stored_total = seen;
                end
                else
                begin
                    stored_total = (seen > 0) ? seen - 1 : 0;
                    cur_preset   = 1;
                end
            end
        end
        else
        begin
            case (op)
                OP_UP:
                begin
                    tune = 1'b1;
                    if (band_mode == BAND_US && f_now + 1 > int'(us_hi))
                        cur_freq = us_lo;
                    else if (band_mode == BAND_JP && f_now + 1 > int'(jp_hi))
                        cur_freq = jp_lo;
                    else
                        cur_freq = cur_freq + 16'd1;
                end
                OP_DOWN:
                begin
                    tune = 1'b1;
                    if (band_mode == BAND_US && (f_now == 0 || f_now - 1 < int'(us_lo)))
                        cur_freq = us_hi;
                    else if (band_mode == BAND_JP && (f_now == 0 || f_now - 1 < int'(jp_lo)))
                        cur_freq = jp_hi;
                    else
                        cur_freq = cur_freq - 16'd1;
                end
                OP_SAVE:
                begin
                    if (stored_total >= DEPTH)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        dup = 1'b0;
                        for (idx = 0; idx < stored_total; idx++)
                        begin
                            if (stations[idx] == cur_freq)
                            begin
                                cur_preset = idx + 1;
                                dup        = 1'b1;
                                break;
                            end
                        end
                        if (!dup)
                        begin
                            stations[stored_total] = cur_freq;
                            stored_total++;
                            cur_preset = stored_total;
                        end
                    end
                end
                OP_DEL_ONE:
                begin
                    if (cur_preset == 0)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        // close the gap and clear the last used slot
                        if (stored_total > 0)
                        begin
                            for (idx = cur_preset; idx < stored_total; idx++)
                                stations[idx - 1] = stations[idx];
                            stations[stored_total - 1] = '0;
                            stored_total--;
                        end
                        cur_preset = 0;
                    end
                end
                OP_DEL_ALL:
                begin
                    foreach (stations[i])
                        stations[i] = '0;
                    cur_preset   = 0;
                    stored_total = 0;
                end
                OP_SET:
                begin
                    cur_freq = nf;
                    tune     = 1'b1;
                end
                default: ;
            endcase
        end
        want.ok           = ok;
        want.tune         = tune;
        want.freq         = cur_freq;
        want.preset       = OUT_CNT_W'(cur_preset);
        want.preset_count = OUT_CNT_W'(stored_total);
        owed_reports.push_back(want);
    endfunction

    function void check_field(string name, logic [FREQ_W-1:0] want, logic [FREQ_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_report(station_report_t got);
        station_report_t want;
        if (owed_reports.size() == 0)
        begin
            $display("%0t: unexpected rsp beat, expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = owed_reports.pop_front();
        check_field("ok", FREQ_W'(want.ok), FREQ_W'(got.ok));
        check_field("tune", FREQ_W'(want.tune), FREQ_W'(got.tune));
        check_field("freq", want.freq, got.freq);
        check_field("preset", FREQ_W'(want.preset), FREQ_W'(got.preset));
        check_field("preset_count", FREQ_W'(want.preset_count), FREQ_W'(got.preset_count));
    endfunction
endclass

module tb_top;

    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         PHASE_ITEMS  = 165;
    localparam int         PHASE_COUNT  = 8;
    localparam int         LONG_HOLD    = 400;
    localparam int         END_SETTLE   = 2 * DEPTH + 8;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;
    localparam logic [1:0] BAND_OPEN_LO = 2'd2;
    localparam logic [1:0] BAND_OPEN_HI = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rpsm_req_if req_ch ();
    rpsm_rsp_if rsp_ch ();

    preset_station_tracker tracker = new();

    int sent_count;
    int burst_left;
    int cycle_count;
    bit solid_stream;
    bit hold_request;

    radio_preset_station_manager_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // beat monitor on both channels
    always @(posedge clk)
    begin
        station_report_t got;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                tracker.note_command(req_ch.op, req_ch.new_freq);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.ok, rsp_ch.tune, rsp_ch.freq, rsp_ch.preset,
                       rsp_ch.preset_count};
                tracker.check_report(got);
            end
        end
    end

    // response backpressure: segments of varying pattern, one long hold on request
    initial
    begin
        int seg_len;
        int seg_mode;
        int held;
        bit hold_taken;
        hold_taken   = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_taken)
            begin
                hold_taken   = 1'b1;
                rsp_ch.ready = 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(negedge clk);
            end
            seg_mode = $urandom_range(0, 3);
            seg_len  = $urandom_range(5, 60);
            repeat (seg_len)
            begin
                @(negedge clk);
                case (seg_mode)
                    0: rsp_ch.ready = 1'b1;
                    1: rsp_ch.ready = 1'($urandom_range(0, 1));
                    2: rsp_ch.ready = ($urandom_range(0, 7) == 0);
                    default: rsp_ch.ready = ~rsp_ch.ready;
                endcase
            end
        end
    end

    // offer one command beat, then either keep the burst going or idle a while
    task automatic send_command(input logic [OP_W-1:0] op, input logic [FREQ_W-1:0] nf);
        int gap;
        req_ch.valid    = 1'b1;
        req_ch.op       = op;
        req_ch.new_freq = nf;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = 0;
            if (!solid_stream && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // stop offering and wait until every report has come back
    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (tracker.owed_reports.size() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // band setting per phase: defaults, open modes, full range, inverted, random
    task automatic apply_setting(input int k);
        logic [1:0]        mode;
        logic [FREQ_W-1:0] ul;
        logic [FREQ_W-1:0] uh;
        logic [FREQ_W-1:0] jl;
        logic [FREQ_W-1:0] jh;
        ul = 16'd875;
        uh = 16'd1080;
        jl = 16'd760;
        jh = 16'd900;
        case (k)
            0: mode = BAND_US;
            1: mode = BAND_JP;
            2:
            begin
                mode = BAND_OPEN_LO;
                ul   = 16'($urandom);
                uh   = 16'($urandom);
                jl   = 16'($urandom);
                jh   = 16'($urandom);
            end
            3: mode = BAND_OPEN_HI;
            4:
            begin
                mode = BAND_US;
                ul   = '0;
                uh   = '1;
                jl   = '0;
                jh   = '1;
            end
            5:
            begin
                mode = BAND_JP;
                ul   = '1;
                uh   = '0;
                jl   = '1;
                jh   = '0;
            end
            default:
            begin
                mode = (k % 2 == 0) ? BAND_US : BAND_JP;
                ul   = 16'($urandom_range(0, 60000));
                uh   = ul + 16'($urandom_range(0, 3000));
                jl   = 16'($urandom_range(0, 60000));
                jh   = jl + 16'($urandom_range(0, 3000));
            end
        endcase
        write_reg(CFG_BAND_MODE, {14'b0, mode});
        write_reg(CFG_US_BOTTOM, ul);
        write_reg(CFG_US_TOP, uh);
        write_reg(CFG_JP_BOTTOM, jl);
        write_reg(CFG_JP_TOP, jh);
    endtask

    // frequencies: zero, all ones, near band limits, a small pool for duplicates, any value
    function automatic logic [FREQ_W-1:0] pick_freq();
        logic [FREQ_W-1:0] f;
        case ($urandom_range(0, 9))
            0: f = '0;
            1: f = '1;
            2, 3, 4:
            begin
                case ($urandom_range(0, 3))
                    0: f = tracker.us_lo;
                    1: f = tracker.us_hi;
                    2: f = tracker.jp_lo;
                    default: f = tracker.jp_hi;
                endcase
                f = f + 16'($urandom_range(0, 2)) - 16'd1;
            end
            5, 6: f = 16'(900 + $urandom_range(0, 15));
            default: f = 16'($urandom);
        endcase
        return f;
    endfunction

    function automatic logic [OP_W-1:0] pick_nav_op();
        logic [OP_W-1:0] op;
        case ($urandom_range(0, 2))
            0: op = OP_NEXT;
            1: op = OP_PREV;
            default: op = OP_CUR;
        endcase
        return op;
    endfunction

    // mixed command sequences until the phase budget is spent
    task automatic run_phase(input int phase_end);
        int n;
        while (sent_count < phase_end)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    n = $urandom_range(1, 12);
                    repeat (n)
                    begin
                        send_command(OP_SET, pick_freq());
                        send_command(OP_SAVE, 16'($urandom));
                    end
                end
                3, 4:
                begin
                    n = $urandom_range(2, 10);
                    repeat (n)
                        send_command(pick_nav_op(), 16'($urandom));
                end
                5:
                begin
                    send_command(OP_SET, pick_freq());
                    n = $urandom_range(1, 6);
                    repeat (n)
                        send_command($urandom_range(0, 1) ? OP_UP : OP_DOWN, 16'($urandom));
                end
                6:
                begin
                    send_command(pick_nav_op(), 16'($urandom));
                    send_command(OP_DEL_ONE, 16'($urandom));
                    if ($urandom_range(0, 3) == 0)
                        send_command(OP_DEL_ONE, 16'($urandom));
                end
                7:
                begin
                    n = $urandom_range(1, 5);
                    repeat (n)
                        send_command(4'($urandom_range(0, 15)), 16'($urandom));
                end
                8:
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_command(OP_DEL_ALL, 16'($urandom));
                    else
                        send_command(OP_SAVE, 16'($urandom));
                end
                default:
                begin
                    send_command($urandom_range(0, 1) ? OP_UP : OP_DOWN, 16'($urandom));
                    send_command(OP_SAVE, 16'($urandom));
                end
            endcase
        end
    endtask

    // main sequence
    initial
    begin
        int phase;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.op       = OP_NEXT;
        req_ch.new_freq = '0;
        sent_count      = 0;
        burst_left      = 0;
        solid_stream    = 1'b0;
        hold_request    = 1'b0;
        rst_n           = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table refusals and delete with nothing selected
        send_command(OP_NEXT, '0);
        send_command(OP_PREV, '1);
        send_command(OP_CUR, '0);
        send_command(OP_DEL_ONE, '0);
        // grid wrap at both band limits, step down from zero
        send_command(OP_SET, 16'd1080);
        send_command(OP_UP, '0);
        send_command(OP_DOWN, '0);
        send_command(OP_SET, '0);
        send_command(OP_DOWN, '0);
        // saves, a duplicate, and a zero entry that breaks the scan
        send_command(OP_SAVE, '0);
        send_command(OP_SET, '1);
        send_command(OP_SAVE, '0);
        send_command(OP_SAVE, '0);
        send_command(OP_SET, '0);
        send_command(OP_SAVE, '0);
        // wrap on next, missing entry on previous and current
        send_command(OP_NEXT, '0);
        send_command(OP_PREV, '0);
        send_command(OP_CUR, '0);
        send_command(OP_DEL_ONE, '0);
        send_command(OP_SPARE_LO, 16'h5555);
        send_command(OP_SPARE_HI, 16'hAAAA);
        send_command(OP_DEL_ALL, '0);
        // delete one with a preset selected but no stored count
        send_command(OP_SET, '0);
        send_command(OP_SAVE, '0);
        send_command(OP_CUR, '0);
        send_command(OP_DEL_ONE, '0);
        wait_idle();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            apply_setting(phase);
            // fill past the table depth so full refusals show up
            if (phase % 2 == 0)
            begin
                repeat (DEPTH + 2)
                begin
                    send_command(OP_SET, pick_freq());
                    send_command(OP_SAVE, 16'($urandom));
                end
            end
            // long receiver hold while commands keep coming
            if (phase == 1)
            begin
                hold_request = 1'b1;
                solid_stream = 1'b1;
                repeat (80)
                begin
                    if ($urandom_range(0, 1))
                        send_command(pick_nav_op(), 16'($urandom));
                    else
                        send_command($urandom_range(0, 1) ? OP_SAVE : OP_SET, pick_freq());
                end
                solid_stream = 1'b0;
                hold_request = 1'b0;
            end
            run_phase(sent_count + PHASE_ITEMS);
            wait_idle();
        end

        repeat (END_SETTLE) @(negedge clk);
        if (tracker.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
